>>> design/imu_pkg.sv
package imu_pkg;

   // lattice geometry
   localparam int ROWS  = 64;
   localparam int COLS  = 64;
   localparam int SITES = ROWS * COLS;
   localparam int ROW_W = $clog2(ROWS);
   localparam int COL_W = $clog2(COLS);

   // item field widths
   localparam int ROW_FIELD_W  = 6;
   localparam int COL_FIELD_W  = 6;
   localparam int FRAC_W       = 32;
   localparam int DE_W         = 5;
   localparam int ENERGY_OUT_W = 15;
   localparam int MAG_OUT_W    = 14;

   // running totals, wide enough for any lattice size
   localparam int ENERGY_MIN_W = $clog2(2 * SITES + 1) + 1;
   localparam int MAG_MIN_W    = $clog2(SITES + 1) + 1;
   localparam int ENERGY_W     = (ENERGY_MIN_W > ENERGY_OUT_W) ? ENERGY_MIN_W : ENERGY_OUT_W;
   localparam int MAG_W        = (MAG_MIN_W > MAG_OUT_W) ? MAG_MIN_W : MAG_OUT_W;

   // req tdata layout
   localparam int REQ_ROW_LSB  = 0;
   localparam int REQ_COL_LSB  = REQ_ROW_LSB + ROW_FIELD_W;
   localparam int REQ_SV_LSB   = REQ_COL_LSB + COL_FIELD_W;
   localparam int REQ_FRAC_LSB = REQ_SV_LSB + 1;
   localparam int REQ_BITS     = REQ_FRAC_LSB + FRAC_W;
   localparam int REQ_DATA_W   = ((REQ_BITS + 7) / 8) * 8;

   // rsp tdata layout
   localparam int RSP_DE_LSB   = 0;
   localparam int RSP_EN_LSB   = RSP_DE_LSB + DE_W;
   localparam int RSP_MAG_LSB  = RSP_EN_LSB + ENERGY_OUT_W;
   localparam int RSP_BITS     = RSP_MAG_LSB + MAG_OUT_W;
   localparam int RSP_DATA_W   = ((RSP_BITS + 7) / 8) * 8;

   // configuration port
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] REG_THRESH_4 = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_THRESH_8 = CSR_IDX_W'(1);

   // item kinds
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_TRIAL = 1'b1;

   localparam int NSUM_W  = 4;
   localparam int DELTA_W = 3;

   typedef struct packed {
      logic                      clr;
      logic                      en;
      logic signed [DELTA_W-1:0] delta;
   } acc_ctrl_type;

   typedef struct packed {
      logic                   accept;
      logic signed [DE_W-1:0] de;
   } decision_type;

   function automatic logic signed [DELTA_W-1:0] spin_of(input logic b);
      spin_of = b ? DELTA_W'(1) : -DELTA_W'(1);
   endfunction

endpackage

>>> design/imu_row_ram.sv
module imu_row_ram import imu_pkg::*; (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [ROW_W-1:0] rd_addr,
   output logic [COLS-1:0]  rd_data,
   input  logic             wr_en,
   input  logic [ROW_W-1:0] wr_addr,
   input  logic [COLS-1:0]  wr_data
);

   // one lattice row per word
   logic [COLS-1:0] mem [ROWS];
   logic [COLS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/imu_flip_unit.sv
module imu_flip_unit import imu_pkg::*; (
   input  logic               clock,
   input  acc_ctrl_type       ctrl,
   input  logic               center_spin,
   input  logic               kind,
   input  logic               spin_value,
   input  logic [FRAC_W-1:0]  frac,
   input  logic [FRAC_W-1:0]  thresh_4,
   input  logic [FRAC_W-1:0]  thresh_8,
   output decision_type       dec
);

   logic signed [NSUM_W-1:0] nsum_ff;
   logic signed [NSUM_W-1:0] nsum_in;
   logic signed [DE_W-1:0]   twice;
   logic signed [DE_W-1:0]   de_raw;
   logic [FRAC_W-1:0]        thresh;
   logic                     accept;

   // neighbour sum built up one row read at a time
   always_comb begin
      nsum_in = nsum_ff;
      if (ctrl.clr) begin
         nsum_in = '0;
      end else if (ctrl.en) begin
         nsum_in = nsum_ff + {ctrl.delta[DELTA_W-1], ctrl.delta};
      end
   end

   always_ff @(posedge clock) begin
      nsum_ff <= nsum_in;
   end

   always_comb begin
      twice  = {nsum_ff, 1'b0};
      de_raw = center_spin ? twice : -twice;
      thresh = (de_raw == DE_W'(8)) ? thresh_8 : thresh_4;
      if (kind == KIND_WRITE) begin
         accept = (spin_value != center_spin);
      end else begin
         accept = (de_raw <= 0) ||
                  (((de_raw == DE_W'(4)) || (de_raw == DE_W'(8))) && (frac <= thresh));
      end
      dec.accept = accept;
      dec.de     = accept ? de_raw : '0;
   end

endmodule

>>> design/ising_metropolis_update.sv
// channel | dir | handshake             | content
// req     | in  | req_tvalid/tready     | tuser: kind; tdata: row, col, spin_value, fraction
// rsp     | out | rsp_tvalid/tready     | tuser: flipped; tdata: de, energy, magnetization
// csr     | in  | csr_valid/csr_ready   | csr_index, csr_data (two threshold registers)
//
// an item runs as three row reads from the single-read-port row memory that
// feed the shared neighbour accumulator, then a decide/write step (out-of-range items go straight to it).
// reset is synchronous; afterwards a clearing pass writes all spins to +1, one row
// per cycle, with req_tready low (csr writes still taken). a waiting result does
// not block accepting an item; the decide cycle holds until the output
// register is free.
module ising_metropolis_update import imu_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // row, col, spin_value, random_fraction
   input  logic                  req_tuser,  // kind
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // energy_change, energy_total, magnetization
   output logic                  rsp_tuser,  // flipped
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_RD_CTR = 3'd2;
   localparam logic [2:0] S_RD_DN  = 3'd3;
   localparam logic [2:0] S_EVAL   = 3'd4;
   localparam logic [2:0] S_DECIDE = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [ROW_W-1:0] clr_cnt_ff, clr_cnt_in;

   logic                 kind_ff, kind_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic                 sv_ff, sv_in;
   logic [FRAC_W-1:0]    frac_ff, frac_in;
   logic                 skip_ff, skip_in;
   logic [COLS-1:0]      ctr_row_ff, ctr_row_in;

   logic signed [ENERGY_W-1:0] energy_ff, energy_in;
   logic signed [MAG_W-1:0]    mag_ff, mag_in;
   logic [FRAC_W-1:0]          th4_ff, th4_in;
   logic [FRAC_W-1:0]          th8_ff, th8_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_user_ff, rsp_user_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [ROW_FIELD_W-1:0] req_row;
   logic [COL_FIELD_W-1:0] req_col;
   logic                   in_range;
   logic [ROW_W-1:0]       req_row_idx;
   logic [ROW_W-1:0]       up_row, dn_row;
   logic [COL_W-1:0]       lf_col, rt_col;
   logic                   req_fire, out_free, apply;

   logic             rd_en, wr_en;
   logic [ROW_W-1:0] rd_addr, wr_addr;
   logic [COLS-1:0]  rd_data, wr_data;

   acc_ctrl_type acc_ctrl;
   decision_type dec;

   imu_row_ram u_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   imu_flip_unit u_flip (
      .clock       (clock),
      .ctrl        (acc_ctrl),
      .center_spin (ctr_row_ff[col_ff]),
      .kind        (kind_ff),
      .spin_value  (sv_ff),
      .frac        (frac_ff),
      .thresh_4    (th4_ff),
      .thresh_8    (th8_ff),
      .dec         (dec)
   );

   assign req_row     = req_tdata[REQ_COL_LSB-1:REQ_ROW_LSB];
   assign req_col     = req_tdata[REQ_SV_LSB-1:REQ_COL_LSB];
   assign in_range    = (32'(req_row) < ROWS) && (32'(req_col) < COLS);
   assign req_row_idx = ROW_W'(req_row);

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // periodic neighbours
   always_comb begin
      up_row = (req_row_idx == '0) ? ROW_W'(ROWS - 1) : req_row_idx - ROW_W'(1);
      dn_row = (row_ff == ROW_W'(ROWS - 1)) ? '0 : row_ff + ROW_W'(1);
      lf_col = (col_ff == '0) ? COL_W'(COLS - 1) : col_ff - COL_W'(1);
      rt_col = (col_ff == COL_W'(COLS - 1)) ? '0 : col_ff + COL_W'(1);
   end

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      kind_in      = kind_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      sv_in        = sv_ff;
      frac_in      = frac_ff;
      skip_in      = skip_ff;
      ctr_row_in   = ctr_row_ff;
      energy_in    = energy_ff;
      mag_in       = mag_ff;
      th4_in       = th4_ff;
      th8_in       = th8_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_user_in  = rsp_user_ff;
      rsp_data_in  = rsp_data_ff;
      rd_en        = 1'b0;
      rd_addr      = row_ff;
      wr_en        = 1'b0;
      wr_addr      = row_ff;
      wr_data      = ctr_row_ff;
      acc_ctrl     = '0;
      apply        = 1'b0;

      if (csr_valid && csr_ready) begin
         if (csr_index == REG_THRESH_4) begin
            th4_in = csr_data;
         end else if (csr_index == REG_THRESH_8) begin
            th8_in = csr_data;
         end
      end

      unique case (state_ff)
         S_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_cnt_ff;
            wr_data    = '1;
            clr_cnt_in = clr_cnt_ff + ROW_W'(1);
            if (clr_cnt_ff == ROW_W'(ROWS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            acc_ctrl.clr = 1'b1;
            if (req_fire) begin
               kind_in = req_tuser;
               row_in  = req_row_idx;
               col_in  = COL_W'(req_col);
               sv_in   = req_tdata[REQ_SV_LSB];
               frac_in = req_tdata[REQ_FRAC_LSB +: FRAC_W];
               skip_in = !in_range;
               rd_en   = in_range;
               rd_addr = up_row;
               state_in = in_range ? S_RD_CTR : S_DECIDE;
            end
         end
         S_RD_CTR: begin
            // up row arrives
            acc_ctrl.en    = 1'b1;
            acc_ctrl.delta = spin_of(rd_data[col_ff]);
            rd_en          = 1'b1;
            rd_addr        = row_ff;
            state_in       = S_RD_DN;
         end
         S_RD_DN: begin
            // center row arrives: left and right neighbours, keep row for write-back
            acc_ctrl.en    = 1'b1;
            acc_ctrl.delta = spin_of(rd_data[lf_col]) + spin_of(rd_data[rt_col]);
            ctr_row_in     = rd_data;
            rd_en          = 1'b1;
            rd_addr        = dn_row;
            state_in       = S_EVAL;
         end
         S_EVAL: begin
            acc_ctrl.en    = 1'b1;
            acc_ctrl.delta = spin_of(rd_data[col_ff]);
            state_in       = S_DECIDE;
         end
         S_DECIDE: begin
            if (out_free) begin
               apply   = dec.accept && !skip_ff;
               wr_en   = apply;
               wr_data = ctr_row_ff ^ (COLS'(1) << col_ff);
               if (apply) begin
                  energy_in = energy_ff + ENERGY_W'(dec.de);
                  mag_in    = ctr_row_ff[col_ff] ? mag_ff - MAG_W'(2) : mag_ff + MAG_W'(2);
               end
               rsp_valid_in = 1'b1;
               rsp_user_in  = apply && (kind_ff == KIND_TRIAL);
               rsp_data_in  = '0;
               rsp_data_in[RSP_DE_LSB +: DE_W] = apply ? dec.de : '0;
               rsp_data_in[RSP_EN_LSB +: ENERGY_OUT_W] = energy_in[ENERGY_OUT_W-1:0];
               rsp_data_in[RSP_MAG_LSB +: MAG_OUT_W]   = mag_in[MAG_OUT_W-1:0];
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         energy_ff    <= ENERGY_W'(-2 * SITES);
         mag_ff       <= MAG_W'(SITES);
         th4_ff       <= '0;
         th8_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         skip_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         energy_ff    <= energy_in;
         mag_ff       <= mag_in;
         th4_ff       <= th4_in;
         th8_ff       <= th8_in;
         rsp_valid_ff <= rsp_valid_in;
         skip_ff      <= skip_in;
      end
      kind_ff     <= kind_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      sv_ff       <= sv_in;
      frac_ff     <= frac_in;
      ctr_row_ff  <= ctr_row_in;
      rsp_user_ff <= rsp_user_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> design/imu_checker.sv
module imu_checker import imu_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   logic signed [DE_W-1:0] rsp_de;
   assign rsp_de = rsp_tdata[RSP_DE_LSB +: DE_W];

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // flip energy changes are multiples of four within -8..8
   a_de_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_de == -DE_W'(8)) || (rsp_de == -DE_W'(4)) || (rsp_de == '0) ||
                     (rsp_de == DE_W'(4)) || (rsp_de == DE_W'(8)))
      else $error("illegal energy change");

   // one item at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted while busy");

   // no result appears right after an item is taken
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result too early");

endmodule

bind ising_metropolis_update imu_checker u_imu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

>>> tb/testbench.sv
module testbench import imu_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 2000;

   typedef struct {
      logic                   kind;
      logic [ROW_FIELD_W-1:0] row;
      logic [COL_FIELD_W-1:0] col;
      logic                   spin_value;
      logic [FRAC_W-1:0]      frac;
   } site_op_type;

   typedef struct {
      logic                    flipped;
      logic [DE_W-1:0]         de;
      logic [ENERGY_OUT_W-1:0] energy;
      logic [MAG_OUT_W-1:0]    mag;
   } lattice_sample_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // row, col, spin_value, random_fraction
   logic                  req_tuser = 1'b0; // kind
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // energy_change, energy_total, magnetization
   logic                  rsp_tuser;        // flipped
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   ising_metropolis_update DUT (.*);

   // shadow lattice and totals
   bit                lattice [ROWS][COLS];
   int                energy_now;
   int                mag_now;
   logic [FRAC_W-1:0] thresh4;
   logic [FRAC_W-1:0] thresh8;

   site_op_type        pending_ops[$];
   lattice_sample_type samples_due[$];
   site_op_type        on_bus;
   int              gap_left;
   int              burst_left;
   int              ready_hold;
   int              idle_cycles;
   int              mismatches = 0;
   int              results_seen = 0;
   logic [ROW_FIELD_W-1:0] window_row = '0;
   logic [COL_FIELD_W-1:0] window_col = '0;

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at result %0d: %s", results_seen, msg);
      mismatches++;
   endtask

   function automatic lattice_sample_type metropolis_step(input site_op_type op);
      lattice_sample_type res;
      int r, c, up, dn, lf, rt, s, nsum, de;
      bit accept;
      r = int'(op.row);
      c = int'(op.col);
      res.flipped = 1'b0;
      res.de = '0;
      if (r < ROWS && c < COLS) begin
         up = (r == 0) ? ROWS - 1 : r - 1;
         dn = (r == ROWS - 1) ? 0 : r + 1;
         lf = (c == 0) ? COLS - 1 : c - 1;
         rt = (c == COLS - 1) ? 0 : c + 1;
         s = lattice[r][c] ? 1 : -1;
         nsum = (lattice[up][c] ? 1 : -1) + (lattice[dn][c] ? 1 : -1)
              + (lattice[r][lf] ? 1 : -1) + (lattice[r][rt] ? 1 : -1);
         de = 2 * s * nsum;
         if (op.kind == KIND_WRITE)
            accept = ((op.spin_value ? 1 : -1) != s);
         else if (de <= 0)
            accept = 1'b1;
         else if (de == 4)
            accept = (op.frac <= thresh4);
         else
            accept = (op.frac <= thresh8);
         if (accept) begin
            lattice[r][c] = ~lattice[r][c];
            energy_now += de;
            mag_now -= 2 * s;
            res.flipped = (op.kind == KIND_TRIAL);
            res.de = DE_W'(de);
         end
      end
      res.energy = ENERGY_OUT_W'(energy_now);
      res.mag = MAG_OUT_W'(mag_now);
      return res;
   endfunction

   function automatic site_op_type site_op(input logic kind, input int row, input int col,
                                           input logic sv, input logic [FRAC_W-1:0] frac);
      site_op_type op;
      op.kind = kind;
      op.row = ROW_FIELD_W'(row);
      op.col = COL_FIELD_W'(col);
      op.spin_value = sv;
      op.frac = frac;
      return op;
   endfunction

   // mostly a small wandering patch so that neighbours interact, some scattered sites
   function automatic site_op_type random_op();
      site_op_type op;
      if ($urandom_range(0, 31) == 0) begin
         window_row = ($urandom_range(0, 2) == 0) ? ROW_FIELD_W'(62) : ROW_FIELD_W'($urandom());
         window_col = ($urandom_range(0, 2) == 0) ? COL_FIELD_W'(62) : COL_FIELD_W'($urandom());
      end
      op.kind = ($urandom_range(0, 9) < 3) ? KIND_WRITE : KIND_TRIAL;
      if ($urandom_range(0, 3) != 0) begin
         op.row = ROW_FIELD_W'(window_row + $urandom_range(0, 3));
         op.col = COL_FIELD_W'(window_col + $urandom_range(0, 3));
      end else begin
         op.row = ROW_FIELD_W'($urandom());
         op.col = COL_FIELD_W'($urandom());
      end
      op.spin_value = 1'($urandom());
      case ($urandom_range(0, 5))
         0: op.frac = '0;
         1: op.frac = '1;
         2: op.frac = thresh4 + $urandom_range(0, 2) - 1;
         3: op.frac = thresh8 + $urandom_range(0, 2) - 1;
         default: op.frac = $urandom();
      endcase
      return op;
   endfunction

   task automatic queue_random(input int count);
      repeat (count) pending_ops.push_back(random_op());
   endtask

   task automatic wait_lattice_idle();
      @(negedge clock);
      while (pending_ops.size() != 0 || req_tvalid || samples_due.size() != 0)
         @(negedge clock);
   endtask

   // thresholds change only with nothing in flight
   task automatic enter_phase(input logic [FRAC_W-1:0] t4, input logic [FRAC_W-1:0] t8);
      wait_lattice_idle();
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= REG_THRESH_4;
      csr_data <= t4;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      thresh4 = t4;
      csr_index <= REG_THRESH_8;
      csr_data <= t8;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      thresh8 = t8;
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      foreach (lattice[r, c]) lattice[r][c] = 1'b1;
      energy_now = -2 * SITES;
      mag_now = SITES;
      thresh4 = '0;
      thresh8 = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // lowest thresholds: only a zero fraction passes an uphill flip
      enter_phase('0, '0);
      pending_ops.push_back(site_op(KIND_TRIAL, 0, 0, 1'b0, 32'd1));
      pending_ops.push_back(site_op(KIND_TRIAL, 0, 0, 1'b0, 32'd0));
      pending_ops.push_back(site_op(KIND_WRITE, 0, 0, 1'b1, 32'hFFFF_FFFF));
      pending_ops.push_back(site_op(KIND_WRITE, 5, 5, 1'b1, 32'd0));
      pending_ops.push_back(site_op(KIND_WRITE, 63, 63, 1'b0, 32'd0));
      pending_ops.push_back(site_op(KIND_WRITE, 63, 0, 1'b0, 32'd0));
      pending_ops.push_back(site_op(KIND_TRIAL, 63, 63, 1'b1, 32'hFFFF_FFFF));
      pending_ops.push_back(site_op(KIND_WRITE, 10, 9, 1'b0, 32'd0));
      pending_ops.push_back(site_op(KIND_WRITE, 10, 11, 1'b0, 32'd0));
      // zero energy change flips unconditionally
      pending_ops.push_back(site_op(KIND_TRIAL, 10, 10, 1'b0, 32'hFFFF_FFFF));
      pending_ops.push_back(site_op(KIND_TRIAL, 9, 10, 1'b0, 32'd5));
      pending_ops.push_back(site_op(KIND_TRIAL, 9, 10, 1'b0, 32'd0));
      pending_ops.push_back(site_op(KIND_WRITE, 0, 63, 1'b0, 32'h8000_0000));
      pending_ops.push_back(site_op(KIND_WRITE, 63, 63, 1'b1, 32'h7FFF_FFFF));
      pending_ops.push_back(site_op(KIND_TRIAL, 0, 0, 1'b1, 32'h8000_0000));
      queue_random(150);

      // highest thresholds: every uphill flip passes, even with the largest fraction
      enter_phase('1, '1);
      pending_ops.push_back(site_op(KIND_TRIAL, 32, 32, 1'b0, 32'hFFFF_FFFF));
      pending_ops.push_back(site_op(KIND_TRIAL, 32, 33, 1'b0, 32'hFFFF_FFFF));
      queue_random(180);

      enter_phase(32'h2C08_0000, 32'h0798_0000);
      queue_random(200);

      enter_phase($urandom(), $urandom());
      queue_random(200);

      enter_phase('0, '1);
      queue_random(150);

      enter_phase('1, '0);
      queue_random(50);

      wait_lattice_idle();
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("[ising_metropolis_update] OK");
      else
         $display("[ising_metropolis_update] ERROR");
      $finish;
   end

   // request driver: bursts of items separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
         burst_left = 0;
      end else begin
         if (req_tvalid && req_tready)
            samples_due.push_back(metropolis_step(on_bus));
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_ops.size() != 0) begin
               on_bus = pending_ops.pop_front();
               req_tuser <= on_bus.kind;
               req_tdata <= REQ_DATA_W'({on_bus.frac, on_bus.spin_value, on_bus.col, on_bus.row});
               req_tvalid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 100)
                                                           : $urandom_range(0, 6);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor with its own stall pattern
   always @(posedge clock) begin
      lattice_sample_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_hold = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (samples_due.size() == 0) begin
               report_mismatch("result with no item outstanding");
            end else begin
               want = samples_due.pop_front();
               if (rsp_tuser !== want.flipped)
                  report_mismatch($sformatf("flipped got %b want %b", rsp_tuser, want.flipped));
               if (rsp_tdata[RSP_DE_LSB +: DE_W] !== want.de)
                  report_mismatch($sformatf("energy_change got %0d want %0d",
                     $signed(rsp_tdata[RSP_DE_LSB +: DE_W]), $signed(want.de)));
               if (rsp_tdata[RSP_EN_LSB +: ENERGY_OUT_W] !== want.energy)
                  report_mismatch($sformatf("energy_total got %0d want %0d",
                     $signed(rsp_tdata[RSP_EN_LSB +: ENERGY_OUT_W]), $signed(want.energy)));
               if (rsp_tdata[RSP_MAG_LSB +: MAG_OUT_W] !== want.mag)
                  report_mismatch($sformatf("magnetization got %0d want %0d",
                     $signed(rsp_tdata[RSP_MAG_LSB +: MAG_OUT_W]), $signed(want.mag)));
            end
            results_seen++;
         end
         if (ready_hold != 0) begin
            ready_hold--;
         end else if (rsp_tready) begin
            rsp_tready <= 1'b0;
            ready_hold = $urandom_range(0, 9);
         end else begin
            rsp_tready <= 1'b1;
            ready_hold = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 8);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("[ising_metropolis_update] ERROR");
            $finish;
         end
      end
   end

endmodule

>>> sim.f
design/imu_pkg.sv
design/imu_row_ram.sv
design/imu_flip_unit.sv
design/ising_metropolis_update.sv
design/imu_checker.sv
tb/testbench.sv
